/* sv/mcr_pkg.sv */
// Shared types and constants of the midpoint circle rasterizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mcr_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = 13;
    localparam int OFS_W         = 13;
    localparam int CTR_W         = 14;
    localparam int RAD_W         = 12;
    localparam int DEC_W         = 20;
    localparam int COLOR_W       = 32;
    localparam int ADDR_W        = 24;
    localparam int PT_W          = 16;
    localparam int ROWCOL_W      = 12;
    localparam int S_DATA_W      = 72;
    localparam int M_DATA_W      = 56;
    localparam int M_USER_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_POINTS    = 8;
    localparam int PIDX_W        = $clog2(NUM_POINTS);

    localparam logic [DEC_W-1:0] DEC_INIT  = DEC_W'(3);
    localparam logic [DEC_W-1:0] STEP_DIAG = DEC_W'(10);
    localparam logic [DEC_W-1:0] STEP_SIDE = DEC_W'(6);

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] DIM_LIMIT    = DIM_W'(MAX_DIMENSION);

    typedef struct packed {
        logic                     fin;
        logic signed [OFS_W-1:0]  ofs_a;
        logic signed [OFS_W-1:0]  ofs_b;
        logic signed [CTR_W-1:0]  cx;
        logic signed [CTR_W-1:0]  cy;
        logic [COLOR_W-1:0]       color;
    } job_t;

endpackage

`default_nettype wire

/* sv/midpoint_circle_rasterizer_unit.sv */
// Top level of the midpoint circle rasterizer: frame registers, front end,
// job queue and point generator. Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
//
//  Channel  Direction  Handshake          Contents
//  s_       in         s_tvalid/s_tready  start or advance request
//  m_       out        m_tvalid/m_tready  one pixel write per point
//  cfg_     in         cfg_wr_en          frame width and height registers
//
// Each start or advance request gives eight results, and an advance on a finished
// circle gives one; the point generator emits one result per cycle while the
// output is not stalled, which sets the rate. A request waits in the job queue,
// and each result passes the stage-one and output registers. Reset is synchronous
// and clears all control state at once; there is no clearing pass. A four-entry
// job queue lets the front end take requests while the output is stalled.
`default_nettype none

module midpoint_circle_rasterizer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // center_x[13:0], center_y[27:14], radius[39:28], color[71:40]
    input  wire logic [mcr_pkg::S_DATA_W-1:0]    s_tdata,
    // func[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pixel_address[23:0], pixel_color[55:24]
    output logic [mcr_pkg::M_DATA_W-1:0]         m_tdata,
    // write_enable[0], finished[1]
    output logic [mcr_pkg::M_USER_W-1:0]         m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mcr_pkg::DIM_W-1:0]       cfg_wdata
);

    logic [mcr_pkg::DIM_W-1:0] width_reg, height_reg;
    logic                      q_full, q_empty, q_push, q_pop;
    mcr_pkg::job_t             push_job, head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mcr_pkg::WIDTH_RESET;
            height_reg <= mcr_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcr_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                mcr_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                default: begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    mcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_data  (s_tdata),
        .q_full   (q_full),
        .in_ready (s_tready),
        .job_push (q_push),
        .job      (push_job)
    );

    mcr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_job)
    );

    mcr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_empty      (q_empty),
        .job          (head_job),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

/* sv/mcr_front.sv */
// Front end: accepts start and advance requests, keeps the circle state and
// issues one point-set job per request. Depends on mcr_pkg.
`default_nettype none

module mcr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic                          in_func,
    input  wire logic [mcr_pkg::S_DATA_W-1:0]  in_data,
    input  wire logic                          q_full,
    output logic                               in_ready,
    output logic                               job_push,
    output mcr_pkg::job_t                      job
);

    logic signed [mcr_pkg::OFS_W-1:0] ofs_x_reg, ofs_x_next;
    logic signed [mcr_pkg::OFS_W-1:0] ofs_y_reg, ofs_y_next;
    logic signed [mcr_pkg::DEC_W-1:0] dec_reg, dec_next;
    logic signed [mcr_pkg::CTR_W-1:0] cx_reg, cx_next;
    logic signed [mcr_pkg::CTR_W-1:0] cy_reg, cy_next;
    logic [mcr_pkg::COLOR_W-1:0]      color_reg, color_next;
    logic                             active_reg, active_next;

    logic signed [mcr_pkg::CTR_W-1:0] in_cx, in_cy;
    logic [mcr_pkg::RAD_W-1:0]        in_rad;
    logic [mcr_pkg::COLOR_W-1:0]      in_color;
    logic                             take;
    logic signed [mcr_pkg::OFS_W-1:0] x1, y1;
    logic signed [mcr_pkg::DEC_W-1:0] x1_w, y1_w;

    assign in_cx    = in_data[13:0];
    assign in_cy    = in_data[27:14];
    assign in_rad   = in_data[39:28];
    assign in_color = in_data[71:40];

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign job_push = take;

    assign x1   = ofs_x_reg + mcr_pkg::OFS_W'(1);
    assign y1   = ofs_y_reg - mcr_pkg::OFS_W'(1);
    assign x1_w = mcr_pkg::DEC_W'(x1);
    assign y1_w = mcr_pkg::DEC_W'(y1);

    always_comb begin
        ofs_x_next  = ofs_x_reg;
        ofs_y_next  = ofs_y_reg;
        dec_next    = dec_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        color_next  = color_reg;
        active_next = active_reg;
        job.fin     = 1'b0;
        if (take) begin
            case (in_func)
                mcr_pkg::FUNC_START: begin
                    cx_next     = in_cx;
                    cy_next     = in_cy;
                    color_next  = in_color;
                    ofs_x_next  = '0;
                    ofs_y_next  = {1'b0, in_rad};
                    dec_next    = mcr_pkg::DEC_INIT - {7'b0, in_rad, 1'b0};
                    active_next = 1'b1;
                end
                mcr_pkg::FUNC_ADVANCE: begin
                    if (!active_reg || (ofs_y_reg < ofs_x_reg)) begin
                        active_next = 1'b0;
                        job.fin     = 1'b1;
                    end else begin
                        ofs_x_next = x1;
                        if (dec_reg > 0) begin
                            ofs_y_next = y1;
                            dec_next   = dec_reg + ((x1_w - y1_w) <<< 2) + mcr_pkg::STEP_DIAG;
                        end else begin
                            dec_next   = dec_reg + (x1_w <<< 2) + mcr_pkg::STEP_SIDE;
                        end
                    end
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end
        job.ofs_a = ofs_x_next;
        job.ofs_b = ofs_y_next;
        job.cx    = cx_next;
        job.cy    = cy_next;
        job.color = color_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_x_reg  <= '0;
            ofs_y_reg  <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            ofs_x_reg  <= ofs_x_next;
            ofs_y_reg  <= ofs_y_next;
            dec_reg    <= dec_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mcr_queue.sv */
// Short job queue between the front end and the point generator.
// Depends on mcr_pkg for the job type and depth.
`default_nettype none

module mcr_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire mcr_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output mcr_pkg::job_t      head
);

    mcr_pkg::job_t mem [mcr_pkg::QUEUE_DEPTH];

    logic [mcr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mcr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mcr_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign full    = (count_reg == mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + mcr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + mcr_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + mcr_pkg::QCNT_W'(do_push) - mcr_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/mcr_back.sv */
// Back end: walks the eight symmetric points of each job, clips them to the
// frame and forms the linear address in a two-stage pipeline. Depends on mcr_pkg.
`default_nettype none

module mcr_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [mcr_pkg::DIM_W-1:0]     frame_width,
    input  wire logic [mcr_pkg::DIM_W-1:0]     frame_height,
    input  wire logic                          q_empty,
    input  wire mcr_pkg::job_t                 job,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mcr_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [mcr_pkg::M_USER_W-1:0]       m_tuser,
    output logic                               m_tlast
);

    logic [mcr_pkg::PIDX_W-1:0]       idx_reg, idx_next;
    logic                             out_ok, s1_ok, gen, pt_last, pt_in;
    logic [mcr_pkg::DIM_W-1:0]        w_lim, h_lim;
    logic signed [mcr_pkg::PT_W-1:0]  sp, sq, col, row;

    logic                             s1_valid_reg;
    logic                             s1_we_reg, s1_last_reg, s1_fin_reg;
    logic [mcr_pkg::ROWCOL_W-1:0]     s1_row_reg, s1_col_reg;
    logic [mcr_pkg::COLOR_W-1:0]      s1_color_reg;

    logic                             out_valid_reg;
    logic                             out_we_reg, out_last_reg, out_fin_reg;
    logic [mcr_pkg::ADDR_W-1:0]       out_addr_reg;
    logic [mcr_pkg::COLOR_W-1:0]      out_color_reg;
    logic [mcr_pkg::ROWCOL_W+mcr_pkg::DIM_W-1:0] prod;

    assign out_ok = !out_valid_reg || m_tready;
    assign s1_ok  = !s1_valid_reg || out_ok;
    assign gen    = s1_ok && !q_empty;

    assign pt_last = job.fin || (idx_reg == mcr_pkg::PIDX_W'(mcr_pkg::NUM_POINTS - 1));
    assign q_pop   = gen && pt_last;

    always_comb begin
        idx_next = idx_reg;
        if (gen) begin
            idx_next = pt_last ? '0 : idx_reg + mcr_pkg::PIDX_W'(1);
        end
    end

    assign w_lim = (frame_width > mcr_pkg::DIM_LIMIT) ? mcr_pkg::DIM_LIMIT : frame_width;
    assign h_lim = (frame_height > mcr_pkg::DIM_LIMIT) ? mcr_pkg::DIM_LIMIT : frame_height;

    // Bit 2 of the point index swaps the offsets, bit 0 negates the column
    // term and bit 1 negates the row term.
    always_comb begin
        sp  = mcr_pkg::PT_W'(idx_reg[2] ? job.ofs_b : job.ofs_a);
        sq  = mcr_pkg::PT_W'(idx_reg[2] ? job.ofs_a : job.ofs_b);
        col = mcr_pkg::PT_W'(job.cx) + (idx_reg[0] ? -sp : sp);
        row = mcr_pkg::PT_W'(job.cy) + (idx_reg[1] ? -sq : sq);
        pt_in = !job.fin && !col[mcr_pkg::PT_W-1] && !row[mcr_pkg::PT_W-1]
                && (col[mcr_pkg::PT_W-2:0] < (mcr_pkg::PT_W-1)'(w_lim))
                && (row[mcr_pkg::PT_W-2:0] < (mcr_pkg::PT_W-1)'(h_lim));
    end

    assign prod = s1_row_reg * w_lim;

    always_ff @(posedge aclk) begin
        if (s1_ok) begin
            s1_we_reg    <= pt_in;
            s1_row_reg   <= row[mcr_pkg::ROWCOL_W-1:0];
            s1_col_reg   <= col[mcr_pkg::ROWCOL_W-1:0];
            s1_color_reg <= job.color;
            s1_last_reg  <= pt_last;
            s1_fin_reg   <= job.fin;
        end
        if (out_ok) begin
            out_we_reg    <= s1_we_reg;
            out_addr_reg  <= s1_we_reg
                ? prod[mcr_pkg::ADDR_W-1:0] + mcr_pkg::ADDR_W'(s1_col_reg) : '0;
            out_color_reg <= s1_color_reg;
            out_last_reg  <= s1_last_reg;
            out_fin_reg   <= s1_fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (s1_ok) begin
                s1_valid_reg <= gen;
            end
            if (out_ok) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_addr_reg};
    assign m_tuser  = {out_fin_reg, out_we_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* sv/mcr_checker.sv */
// Port-level checks of the midpoint circle rasterizer, bound to the top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer_unit.
`default_nettype none

module mcr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mcr_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [mcr_pkg::M_USER_W-1:0]  m_tuser,
    input wire logic                          m_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_finished_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
        else $error("finished result is not a lone unwritten result");

    a_clipped_address_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[mcr_pkg::ADDR_W-1:0] == '0))
        else $error("clipped point carries an address");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
